@@ sv/pst_pkg.sv @@
`timescale 1ns / 1ps

package pst_pkg;

   // fixed field widths
   localparam int LINE_W   = 14;
   localparam int PRIO_W   = 16;
   localparam int HID_W    = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int COUNT_W  = 4;

   // request kinds
   localparam logic KIND_ADD    = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_MERGED    = 3'd0,
      STAT_INSERTED  = 3'd1,
      STAT_INVALID   = 3'd2,
      STAT_DUPLICATE = 3'd3,
      STAT_FULL      = 3'd4,
      STAT_CLEARED   = 3'd5,
      STAT_REMOVED   = 3'd6,
      STAT_NOTFOUND  = 3'd7
   } status_type;

   typedef struct packed {
      logic              kind;
      logic [LINE_W-1:0] line_mask;
      logic [HID_W-1:0]  handler;
      logic [PRIO_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
      logic [LINE_W-1:0]  present_lines;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [LINE_W-1:0] lines;
      logic [PRIO_W-1:0] prio;
      logic [HID_W-1:0]  hid;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_STEP,
      OP_MERGE,
      OP_INSERT,
      OP_CLEAR,
      OP_DELETE,
      OP_PUBLISH
   } dp_op_type;

   // controller to datapath
   typedef struct packed {
      dp_op_type  op;
      logic       note;      // latch status and slot this cycle
      status_type status;
      logic       slot_hit;  // slot is the walk index, else zero
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_remove;
      logic invalid;
      logic dup;
      logic full;
      logic last;
      logic occ;
      logic match_add;
      logic place_add;
      logic hit_rm;
      logic empties;
   } dp_stat_type;

endpackage

@@ sv/pst_datapath.sv @@
`timescale 1ns / 1ps

module pst_datapath #(
   parameter int LINE_COUNT = 14
) (
   input  logic                clock,
   input  logic                reset,
   input  pst_pkg::dp_cmd_type cmd,
   input  pst_pkg::req_type    req_data,
   output pst_pkg::dp_stat_type stat,
   output pst_pkg::rsp_type    rsp_data
);
   import pst_pkg::*;

   localparam int IDX_W   = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
   localparam int CNT_W   = $clog2(LINE_COUNT + 1);
   localparam int SCOPE_N = (LINE_COUNT < LINE_W) ? LINE_COUNT : LINE_W;
   localparam logic [LINE_W-1:0] SCOPE = LINE_W'((64'd1 << SCOPE_N) - 64'd1);

   entry_type          tbl_ff [LINE_COUNT];
   entry_type          tbl_in [LINE_COUNT];
   entry_type          prev_entry [LINE_COUNT];
   entry_type          next_entry [LINE_COUNT];
   entry_type          cur;
   entry_type          new_entry;
   logic [LINE_W-1:0]  present_ff, present_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               kind_ff, kind_in;
   logic [LINE_W-1:0]  mask_ff, mask_in;
   logic [HID_W-1:0]   hid_ff, hid_in;
   logic [PRIO_W-1:0]  prio_ff, prio_in;
   status_type         status_ff, status_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   rsp_type            rsp_ff, rsp_in;
   logic [LINE_W-1:0]  gone;

   // neighbor taps for the shift moves
   for (genvar g = 0; g < LINE_COUNT; g++) begin : g_taps
      if (g == 0) begin : g_first
         assign prev_entry[g] = '0;
      end else begin : g_prev
         assign prev_entry[g] = tbl_ff[g-1];
      end
      if (g == LINE_COUNT - 1) begin : g_lastt
         assign next_entry[g] = '0;
      end else begin : g_next
         assign next_entry[g] = tbl_ff[g+1];
      end
   end

   // entry under the walk index
   assign cur       = tbl_ff[idx_ff];
   assign gone      = cur.lines & mask_ff;
   assign new_entry = '{lines: mask_ff, prio: prio_ff, hid: hid_ff};

   // status back to the controller
   always_comb begin
      stat.is_remove = (kind_ff == KIND_REMOVE);
      stat.invalid   = (mask_ff == '0) || (hid_ff == '0);
      stat.dup       = (present_ff & mask_ff) != '0;
      stat.full      = (count_ff == CNT_W'(LINE_COUNT));
      stat.last      = (idx_ff == IDX_W'(LINE_COUNT - 1));
      stat.occ       = (cur.lines != '0);
      stat.match_add = stat.occ && (cur.prio == prio_ff) && (cur.hid == hid_ff);
      stat.place_add = !stat.occ || (cur.prio > prio_ff);
      stat.hit_rm    = (gone != '0);
      stat.empties   = (cur.lines & ~mask_ff) == '0;
   end

   // table update
   always_comb begin
      for (int k = 0; k < LINE_COUNT; k++) begin
         tbl_in[k] = tbl_ff[k];
         unique case (cmd.op)
            OP_MERGE: begin
               if (IDX_W'(k) == idx_ff) begin
                  tbl_in[k].lines = tbl_ff[k].lines | mask_ff;
               end
            end
            OP_INSERT: begin
               if (IDX_W'(k) == idx_ff) begin
                  tbl_in[k] = new_entry;
               end else if (IDX_W'(k) > idx_ff) begin
                  tbl_in[k] = prev_entry[k];
               end
            end
            OP_CLEAR: begin
               if (IDX_W'(k) == idx_ff) begin
                  tbl_in[k].lines = tbl_ff[k].lines & ~mask_ff;
               end
            end
            OP_DELETE: begin
               if (IDX_W'(k) >= idx_ff) begin
                  tbl_in[k] = next_entry[k];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // summary state, request hold, walk index, result
   always_comb begin
      present_in = present_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      kind_in    = kind_ff;
      mask_in    = mask_ff;
      hid_in     = hid_ff;
      prio_in    = prio_ff;
      rsp_in     = rsp_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            kind_in = req_data.kind;
            mask_in = req_data.line_mask & SCOPE;
            hid_in  = req_data.handler;
            prio_in = req_data.priority_req;
            idx_in  = '0;
         end
         OP_STEP: begin
            idx_in = idx_ff + IDX_W'(1);
         end
         OP_MERGE: begin
            present_in = present_ff | mask_ff;
         end
         OP_INSERT: begin
            present_in = present_ff | mask_ff;
            count_in   = count_ff + CNT_W'(1);
         end
         OP_CLEAR: begin
            present_in = present_ff & ~gone;
         end
         OP_DELETE: begin
            present_in = present_ff & ~gone;
            if (count_ff != '0) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_PUBLISH: begin
            rsp_in.status        = status_ff;
            rsp_in.slot          = SLOT_W'(slot_ff);
            rsp_in.present_lines = present_ff;
            rsp_in.entry_count   = COUNT_W'(count_ff);
         end
         default: begin
         end
      endcase
      status_in = cmd.note ? cmd.status : status_ff;
      slot_in   = cmd.note ? (cmd.slot_hit ? idx_ff : '0) : slot_ff;
   end

   // control-side state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LINE_COUNT; k++) begin
            tbl_ff[k] <= '0;
         end
         present_ff <= '0;
         count_ff   <= '0;
      end else begin
         for (int k = 0; k < LINE_COUNT; k++) begin
            tbl_ff[k] <= tbl_in[k];
         end
         present_ff <= present_in;
         count_ff   <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      kind_ff   <= kind_in;
      mask_ff   <= mask_in;
      hid_ff    <= hid_in;
      prio_ff   <= prio_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

@@ sv/pst_ctrl.sv @@
`timescale 1ns / 1ps

module pst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pst_pkg::dp_stat_type stat,
   output pst_pkg::dp_cmd_type  cmd
);
   import pst_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.note     = 1'b0;
      cmd.status   = STAT_NOTFOUND;
      cmd.slot_hit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         // up-front checks for add
         ST_CHECK: begin
            if (stat.is_remove) begin
               state_in = ST_WALK;
            end else if (stat.invalid) begin
               cmd.note   = 1'b1;
               cmd.status = STAT_INVALID;
               state_in   = ST_FINISH;
            end else if (stat.dup) begin
               cmd.note   = 1'b1;
               cmd.status = STAT_DUPLICATE;
               state_in   = ST_FINISH;
            end else begin
               state_in = ST_WALK;
            end
         end
         // one slot per cycle
         ST_WALK: begin
            cmd.note = 1'b1;
            state_in = ST_FINISH;
            if (!stat.is_remove) begin
               priority if (stat.match_add) begin
                  cmd.op       = OP_MERGE;
                  cmd.status   = STAT_MERGED;
                  cmd.slot_hit = 1'b1;
               end else if (stat.place_add && !stat.full) begin
                  cmd.op       = OP_INSERT;
                  cmd.status   = STAT_INSERTED;
                  cmd.slot_hit = 1'b1;
               end else if (stat.place_add || stat.last) begin
                  cmd.status = STAT_FULL;
               end else begin
                  cmd.note = 1'b0;
                  cmd.op   = OP_STEP;
                  state_in = ST_WALK;
               end
            end else begin
               priority if (!stat.occ) begin
                  cmd.status = STAT_NOTFOUND;
               end else if (stat.hit_rm && stat.empties) begin
                  cmd.op       = OP_DELETE;
                  cmd.status   = STAT_REMOVED;
                  cmd.slot_hit = 1'b1;
               end else if (stat.hit_rm) begin
                  cmd.op       = OP_CLEAR;
                  cmd.status   = STAT_CLEARED;
                  cmd.slot_hit = 1'b1;
               end else if (stat.last) begin
                  cmd.status = STAT_NOTFOUND;
               end else begin
                  cmd.note = 1'b0;
                  cmd.op   = OP_STEP;
                  state_in = ST_WALK;
               end
            end
         end
         // load the output register once it is free
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ sv/priority_sorted_handler_table.sv @@
// channel | ports                        | beat
// req     | req_valid req_ready req_data  | kind, line_mask, handler, priority_req
// rsp     | rsp_valid rsp_ready rsp_data  | status, slot, present_lines, entry_count
//
// one beat in, one beat out; an item passes load, check, table walk and publish
// in that order, the walk visiting n slots (0 for a rejected add, else 1 to
// LINE_COUNT) one slot per cycle; the next request is taken once the result is published
// inserts and deletes shift all table entries past the slot by one, in parallel
// synchronous reset empties the table, the present-lines mask and the entry count
// a new request is taken while the previous result still waits on rsp_ready,
// and then holds in its final step until the output register is free
`timescale 1ns / 1ps

module priority_sorted_handler_table #(
   parameter int LINE_COUNT = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pst_pkg::rsp_type rsp_data
);
   import pst_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   pst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pst_datapath #(
      .LINE_COUNT (LINE_COUNT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
